// ===== hdl/isettab_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isettab_pkg
// Shared types and constants for the integer set table.
// ----------------------------------------------------------------------------
package isettab_pkg;

  localparam int CAPACITY = 16;
  // address and count widths; count must reach CAPACITY itself
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int DW = 32;
  localparam int MCW = 5;  // width of the member_count field

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_QUERY  = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_APPLY,
    ST_SH_RD,
    ST_SH_WR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic          re;
    logic [AW-1:0] raddr;
    logic          we;
    logic [AW-1:0] waddr;
    logic [DW-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic                 full_drop;
    logic signed [DW-1:0] oldest_value;
    logic                 is_empty;
    logic [MCW-1:0]       member_count;
    logic                 was_present;
  } result_t;

endpackage

// ===== hdl/isettab_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isettab_ram
// Simple dual-port synchronous RAM, one write and one registered read.
// ----------------------------------------------------------------------------
module isettab_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/isettab_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isettab_ctrl
// Request sequencer: scans the entry RAM for the value, then appends or
// closes the gap by moving later entries down one place.
// ----------------------------------------------------------------------------
module isettab_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  logic [1:0]                    req_mode,
  input  logic signed [isettab_pkg::DW-1:0] req_value,
  output isettab_pkg::mem_req_t         mem_req,
  input  logic [isettab_pkg::DW-1:0]    mem_rdata,
  output logic                          res_valid,
  input  logic                          res_ready,
  output isettab_pkg::result_t          res
);

  localparam int CW = isettab_pkg::CW;
  localparam int AW = isettab_pkg::AW;
  localparam logic [CW-1:0] CAP = CW'(isettab_pkg::CAPACITY);

  isettab_pkg::state_t state_r, state_nxt;
  logic [1:0]                     mode_r, mode_nxt;
  logic [isettab_pkg::DW-1:0]     value_r, value_nxt;
  logic [CW-1:0]                  idx_r, idx_nxt;
  logic [CW-1:0]                  count_r, count_nxt;
  logic [isettab_pkg::DW-1:0]     oldest_r, oldest_nxt;
  logic                           hit_r, hit_nxt;
  logic                           drop_r, drop_nxt;
  logic [CW:0]                    idx_inc;
  logic [31:0]                    count_wide;

  assign idx_inc    = {1'b0, idx_r} + (CW + 1)'(1);
  assign count_wide = 32'(count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= isettab_pkg::ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r   <= mode_nxt;
    value_r  <= value_nxt;
    idx_r    <= idx_nxt;
    oldest_r <= oldest_nxt;
    hit_r    <= hit_nxt;
    drop_r   <= drop_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    mode_nxt   = mode_r;
    value_nxt  = value_r;
    idx_nxt    = idx_r;
    count_nxt  = count_r;
    oldest_nxt = oldest_r;
    hit_nxt    = hit_r;
    drop_nxt   = drop_r;
    req_ready  = 1'b0;
    res_valid  = 1'b0;
    mem_req    = '0;

    case (state_r)
      isettab_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          mode_nxt  = req_mode;
          value_nxt = req_value;
          idx_nxt   = '0;
          hit_nxt   = 1'b0;
          drop_nxt  = 1'b0;
          state_nxt = isettab_pkg::ST_SCAN_RD;
        end
      end
      isettab_pkg::ST_SCAN_RD: begin
        if (idx_r < count_r) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = idx_r[AW-1:0];
          state_nxt     = isettab_pkg::ST_SCAN_CMP;
        end else begin
          state_nxt = isettab_pkg::ST_APPLY;
        end
      end
      isettab_pkg::ST_SCAN_CMP: begin
        if (mem_rdata == value_r) begin
          hit_nxt   = 1'b1;           // idx_r now holds the slot
          state_nxt = isettab_pkg::ST_APPLY;
        end else begin
          idx_nxt   = idx_inc[CW-1:0];
          state_nxt = isettab_pkg::ST_SCAN_RD;
        end
      end
      isettab_pkg::ST_APPLY: begin
        state_nxt = isettab_pkg::ST_DONE;
        case (mode_r)
          isettab_pkg::MODE_INSERT: begin
            if (!hit_r) begin
              if (count_r < CAP) begin
                mem_req.we    = 1'b1;
                mem_req.waddr = count_r[AW-1:0];
                mem_req.wdata = value_r;
                if (count_r == '0) begin
                  oldest_nxt = value_r;
                end
                count_nxt = count_r + CW'(1);
              end else begin
                drop_nxt = 1'b1;
              end
            end
          end
          isettab_pkg::MODE_REMOVE: begin
            if (hit_r) begin
              state_nxt = isettab_pkg::ST_SH_RD;
            end
          end
          default: begin
          end
        endcase
      end
      isettab_pkg::ST_SH_RD: begin
        if (idx_inc < {1'b0, count_r}) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = idx_inc[AW-1:0];
          state_nxt     = isettab_pkg::ST_SH_WR;
        end else begin
          count_nxt = count_r - CW'(1);
          state_nxt = isettab_pkg::ST_DONE;
        end
      end
      isettab_pkg::ST_SH_WR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = idx_r[AW-1:0];
        mem_req.wdata = mem_rdata;
        if (idx_r == '0) begin
          oldest_nxt = mem_rdata;
        end
        idx_nxt   = idx_inc[CW-1:0];
        state_nxt = isettab_pkg::ST_SH_RD;
      end
      isettab_pkg::ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = isettab_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = isettab_pkg::ST_IDLE;
      end
    endcase
  end

  // result reflects the state after the request has been applied
  always_comb begin
    res.was_present  = hit_r;
    res.member_count = count_wide[isettab_pkg::MCW-1:0];
    res.is_empty     = (count_r == '0);
    res.oldest_value = (count_r == '0) ? '0 : $signed(oldest_r);
    res.full_drop    = drop_r;
  end

endmodule

// ===== hdl/integer_set_table_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_set_table_core
// Bounded set of distinct signed 32-bit integers kept in insertion order.
// ----------------------------------------------------------------------------
// Each input item inserts (mode 0), removes (mode 1) or looks up (mode 2 or 3)
// a value and yields exactly one result item. Values sit in a single RAM of
// CAPACITY entries with a registered read, and one item is handled at a time:
// the lookup reads the held entries in turn, comparing each read value, until
// a match or the end of the held values, and a removal then moves each later
// entry down, reading it and writing it one place lower.
// A finished result waits in an output register, and the next item is taken
// the cycle after the result moves into that register.
// No clearing pass is needed after reset; only entries below the count are
// read.
// ----------------------------------------------------------------------------
module integer_set_table_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // mode[1:0], value[33:2], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // was_present[0], member_count[5:1],
                                  // is_empty[6], oldest_value[38:7],
                                  // full_drop[39]
);

  isettab_pkg::mem_req_t       mem_req;
  logic [isettab_pkg::DW-1:0]  mem_rdata;
  isettab_pkg::result_t        res;
  isettab_pkg::result_t        out_data_r;
  logic                        res_valid;
  logic                        res_ready;
  logic                        out_valid_r, out_valid_nxt;

  assign res_ready = !out_valid_r || out_tready;

  isettab_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req_mode  (in_tdata[1:0]),
    .req_value ($signed(in_tdata[33:2])),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  isettab_ram #(
    .DEPTH  (isettab_pkg::CAPACITY),
    .WIDTH  (isettab_pkg::DW),
    .ADDR_W (isettab_pkg::AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== test/isettab_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isettab_checker
// Passive scoreboard for the integer set table core.
// ----------------------------------------------------------------------------
// Watches both streams. Every accepted request is applied to a private copy
// of the set, which gives the result it must produce. Results are queued and
// compared field by field, in order, with the items that leave the block.
// ----------------------------------------------------------------------------
module isettab_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,    // mode[1:0], value[33:2], zero pad
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,   // was_present[0], member_count[5:1],
                                   // is_empty[6], oldest_value[38:7],
                                   // full_drop[39]
  output int          fail_count,
  output int          pending,
  output int          results_checked,
  output int          drops_seen,
  output int          hits_seen
);

  // private copy of the set, oldest first; only entries below held_count are valid
  logic [isettab_pkg::DW-1:0] held_vals [isettab_pkg::CAPACITY];
  int unsigned                held_count;
  isettab_pkg::result_t       expected_results [$];

  function automatic isettab_pkg::result_t apply_request(
      input logic [1:0] mode, input logic [isettab_pkg::DW-1:0] value);
    isettab_pkg::result_t r;
    int unsigned          slot;
    logic                 hit;
    hit  = 1'b0;
    slot = 0;
    for (int unsigned i = 0; i < held_count; i++) begin
      if (!hit && held_vals[i] == value) begin
        hit  = 1'b1;
        slot = i;
      end
    end
    r = '0;
    r.was_present = hit;
    if (mode == isettab_pkg::MODE_INSERT) begin
      if (!hit) begin
        if (held_count < isettab_pkg::CAPACITY) begin
          held_vals[held_count] = value;
          held_count++;
        end else begin
          r.full_drop = 1'b1;
        end
      end
    end else if (mode == isettab_pkg::MODE_REMOVE && hit) begin
      // close the gap, keeping the order of later entries
      for (int unsigned i = slot; i + 1 < held_count; i++)
        held_vals[i] = held_vals[i + 1];
      held_count--;
    end
    // anything else, the spare mode too, is a plain lookup
    r.member_count = held_count[isettab_pkg::MCW-1:0];
    r.is_empty     = (held_count == 0);
    r.oldest_value = (held_count > 0) ? held_vals[0] : '0;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    isettab_pkg::result_t got;
    isettab_pkg::result_t want;
    if (!rst_n) begin
      expected_results.delete();
      held_count      = 0;
      fail_count      = 0;
      results_checked = 0;
      drops_seen      = 0;
      hits_seen       = 0;
    end else begin
      // results first: an item taken at this edge cannot answer at the same one
      if (out_tvalid && out_tready) begin
        got = isettab_pkg::result_t'(out_tdata);
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing expected, expected none, got 0x%0h",
                   $time, out_tdata);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("was_present", 32'(want.was_present), 32'(got.was_present));
          check_field("member_count", 32'(want.member_count), 32'(got.member_count));
          check_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
          check_field("oldest_value", want.oldest_value, got.oldest_value);
          check_field("full_drop", 32'(want.full_drop), 32'(got.full_drop));
          results_checked++;
          if (want.full_drop) drops_seen++;
          if (want.was_present) hits_seen++;
        end
      end
      if (in_tvalid && in_tready)
        expected_results.push_back(apply_request(in_tdata[1:0], in_tdata[33:2]));
    end
    pending = expected_results.size();
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the integer set table core.
// ----------------------------------------------------------------------------
// A directed opening walks the extreme values, every mode, repeated and
// absent values, removal from the middle and the front, and a fill past
// capacity. Random requests then draw mostly from a small value pool so that
// hits, removals and full drops are common, in phases that grow and shrink
// the set. Both streams idle at random; the receiver also holds off for a
// long stretch. The checker module does the prediction and comparison.
// ----------------------------------------------------------------------------
module tb;

  localparam logic [1:0] MODE_SPARE = 2'd3;  // unused code, acts as a lookup
  localparam int RANDOM_ITEMS = 1400;
  localparam int POOL_SIZE    = 24;
  // limit for the whole run; all the items sent, with their stalls and gaps,
  // stay far below this
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 4 * isettab_pkg::CAPACITY + 16;
  localparam int HOLD_START   = 4000;
  localparam int HOLD_LEN     = 400;
  localparam int CALM_START   = 20000;
  localparam int CALM_END     = 30000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;

  int          fail_count;
  int          pending;
  int          results_checked;
  int          drops_seen;
  int          hits_seen;
  int unsigned cycle_count;
  int unsigned requests_sent;
  bit          sender_idles;
  logic [isettab_pkg::DW-1:0] value_pool [POOL_SIZE];

  integer_set_table_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  isettab_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked),
    .drops_seen      (drops_seen),
    .hits_seen       (hits_seen)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial cycle_count = 0;
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("%0t: timeout with %0d results outstanding", $time, pending);
    $display("integer_set_table_core test failed");
    $finish;
  end

  // receiver: random stalls, one long hold-off, one calm stretch
  initial begin : result_sink
    int unsigned n;
    n = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      n++;
      if (n >= HOLD_START && n < HOLD_START + HOLD_LEN)
        out_tready <= 1'b0;
      else if (n >= CALM_START && n < CALM_END)
        out_tready <= 1'b1;
      else
        out_tready <= ($urandom_range(99) >= 13);
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(input logic [1:0] mode,
                              input logic [isettab_pkg::DW-1:0] value);
    if (sender_idles && $urandom_range(99) < 13) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, value, mode};
    do @(posedge clk); while (!in_tready);
    requests_sent++;
    @(negedge clk);
  endtask

  // phase 0 grows the set, phase 1 is balanced, phase 2 drains it
  function automatic logic [1:0] pick_mode(input int phase);
    int unsigned r;
    int unsigned ins_lim;
    r = $urandom_range(99);
    ins_lim = (phase == 0) ? 60 : (phase == 1) ? 40 : 20;
    if (r < ins_lim) return isettab_pkg::MODE_INSERT;
    if (r < 75)      return isettab_pkg::MODE_REMOVE;
    if (r < 95)      return isettab_pkg::MODE_QUERY;
    return MODE_SPARE;
  endfunction

  initial begin : stimulus
    logic [isettab_pkg::DW-1:0] v;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    requests_sent = 0;
    sender_idles  = 1'b1;
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7FFF_FFFF;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < POOL_SIZE; i++) value_pool[i] = $urandom;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_request(isettab_pkg::MODE_INSERT, 32'h8000_0000);
    send_request(isettab_pkg::MODE_INSERT, 32'h7FFF_FFFF);
    send_request(isettab_pkg::MODE_INSERT, 32'h0000_0000);
    send_request(isettab_pkg::MODE_INSERT, 32'hFFFF_FFFF);
    send_request(isettab_pkg::MODE_INSERT, 32'h7FFF_FFFF);  // already held
    send_request(isettab_pkg::MODE_QUERY, 32'h8000_0000);
    send_request(isettab_pkg::MODE_QUERY, 32'h1234_5678);   // absent
    send_request(MODE_SPARE, 32'h0000_0000);
    send_request(isettab_pkg::MODE_REMOVE, 32'h0000_0000);  // from the middle
    send_request(isettab_pkg::MODE_REMOVE, 32'h0BAD_F00D);  // absent
    send_request(isettab_pkg::MODE_REMOVE, 32'h8000_0000);  // the oldest
    send_request(isettab_pkg::MODE_INSERT, 32'h5555_5555);
    send_request(isettab_pkg::MODE_INSERT, 32'hAAAA_AAAA);
    for (int i = 0; i < 12; i++)
      send_request(isettab_pkg::MODE_INSERT, 32'h0101_0101 * (i + 2));
    send_request(isettab_pkg::MODE_INSERT, 32'hFFFF_0000);  // set is full: dropped
    send_request(isettab_pkg::MODE_INSERT, 32'h7FFF_FFFF);  // held while full: not dropped

    // let the block drain before the random part
    in_tvalid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      sender_idles = !(k >= 500 && k < 800);
      if (k == RANDOM_ITEMS / 2) begin
        in_tvalid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
      end
      if ($urandom_range(9) == 0) v = $urandom;
      else v = value_pool[$urandom_range(POOL_SIZE - 1)];
      send_request(pick_mode((k / 120) % 3), v);
    end
    in_tvalid <= 1'b0;

    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d requests; %0d results checked in %0d cycles.",
             requests_sent, results_checked, cycle_count);
    $display("Results covered %0d values found present and %0d inserts refused when full.",
             hits_seen, drops_seen);
    if (fail_count == 0) begin
      $display("integer_set_table_core test passed");
    end else begin
      $display("integer_set_table_core test failed");
    end
    $finish;
  end

endmodule
